// ===== design/glob_wildcard_matcher_defines.svh =====
// ============================================================================
// Glob wildcard matcher assertion macros
// Shared assertion forms for the checker of the glob wildcard matcher.
// ============================================================================
`ifndef GLOB_WILDCARD_MATCHER_DEFINES_SVH
`define GLOB_WILDCARD_MATCHER_DEFINES_SVH

// Property checked at every clock edge outside reset.
`define GWM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Property checked at every clock edge, reset included.
`define GWM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/gwm_pkg.sv =====
// ============================================================================
// Glob wildcard matcher package
// Command codes, character constants, the decoded command struct and the
// case folding function used across the matcher.
// ============================================================================
package gwm_pkg;

    // Default pattern store depth.
    localparam int GWM_MAX_PATTERN = 32;

    // Command codes carried on the input tuser field.
    localparam logic [1:0] FUNC_START    = 2'd0;
    localparam logic [1:0] FUNC_PAT_CHAR = 2'd1;
    localparam logic [1:0] FUNC_TXT_CHAR = 2'd2;
    localparam logic [1:0] FUNC_TXT_END  = 2'd3;

    // Wildcard characters.
    localparam logic [7:0] STAR_CODE  = 8'h2A;
    localparam logic [7:0] QMARK_CODE = 8'h3F;

    // Bounds of the upper-case ASCII range and the folding offset.
    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] UPPER_Z    = 8'h5A;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    // One decoded command, handed from the control stage to the datapath.
    typedef struct packed {
        logic start;
        logic pat_wr;
        logic txt_step;
        logic txt_end;
    } t_op;

    // Fold ASCII upper case letters to lower case.
    function automatic logic [7:0] fold_lower(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= UPPER_A && b <= UPPER_Z) begin
            r = b + CASE_DELTA;
        end
        return r;
    endfunction

endpackage

// ===== design/gwm_pattern_store.sv =====
// ============================================================================
// Glob wildcard matcher pattern store
// Holds the pattern bytes, the pattern length and the overflow flag, and
// presents per-position star, question mark and in-range masks.
// ============================================================================
module gwm_pattern_store
    import gwm_pkg::*;
#(
    parameter int MAX_PATTERN = GWM_MAX_PATTERN,
    localparam int LW = $clog2(MAX_PATTERN + 1),
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_op                    i_op,
    input  logic [7:0]             i_char,
    output logic [LW-1:0]          o_len,
    output logic                   o_ovf,
    output logic [7:0]             o_bytes [MAX_PATTERN],
    output logic [MAX_PATTERN-1:0] o_star,
    output logic [MAX_PATTERN-1:0] o_qmark,
    output logic [MAX_PATTERN-1:0] o_valid
);

    logic [7:0]    r_bytes [MAX_PATTERN];
    logic [LW-1:0] r_len;
    logic [LW-1:0] n_len;
    logic          r_ovf;
    logic          n_ovf;
    logic          w_full;
    logic          w_wr;

    assign w_full = (r_len >= LW'(MAX_PATTERN));
    assign w_wr   = i_op.pat_wr && !w_full;

    // Length and overflow tracking.
    always_comb begin
        n_len = r_len;
        n_ovf = r_ovf;
        if (i_op.start) begin
            n_len = '0;
            n_ovf = 1'b0;
        end else if (i_op.pat_wr) begin
            if (w_full) begin
                n_ovf = 1'b1;
            end else begin
                n_len = r_len + LW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_len <= n_len;
            r_ovf <= n_ovf;
        end
    end

    // Pattern bytes are written at the current length; no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_bytes[r_len[IW-1:0]] <= i_char;
        end
    end

    // Per-position masks; positions at or beyond the length read as empty.
    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            o_valid[i] = (LW'(i) < r_len);
            o_star[i]  = o_valid[i] && (r_bytes[i] == STAR_CODE);
            o_qmark[i] = o_valid[i] && (r_bytes[i] == QMARK_CODE);
            o_bytes[i] = r_bytes[i];
        end
    end

    assign o_len = r_len;
    assign o_ovf = r_ovf;

endmodule

// ===== design/gwm_active_set.sv =====
// ============================================================================
// Glob wildcard matcher active position set
// Keeps the set of live pattern positions, closes it over star positions
// with one carry chain, advances it by one text byte and reports a match.
// ============================================================================
module gwm_active_set
    import gwm_pkg::*;
#(
    parameter int MAX_PATTERN = GWM_MAX_PATTERN,
    localparam int LW = $clog2(MAX_PATTERN + 1),
    localparam int SW = MAX_PATTERN + 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_op                    i_op,
    input  logic [7:0]             i_char,
    input  logic [LW-1:0]          i_len,
    input  logic                   i_ovf,
    input  logic [7:0]             i_bytes [MAX_PATTERN],
    input  logic [MAX_PATTERN-1:0] i_star,
    input  logic [MAX_PATTERN-1:0] i_qmark,
    input  logic [MAX_PATTERN-1:0] i_valid,
    output logic                   o_matched
);

    logic [SW-1:0]          r_set;
    logic [SW-1:0]          n_set;
    logic [SW-1:0]          w_star_ext;
    logic [SW-1:0]          w_gen;
    logic [SW-1:0]          w_sum;
    logic [SW-1:0]          w_carry;
    logic [SW-1:0]          w_closed;
    logic [MAX_PATTERN-1:0] w_hit;
    logic [SW-1:0]          w_next;

    // Star closure: a live star position also makes the next one live, and
    // runs of stars chain. This is a carry chain with generate = live star
    // and propagate = star, so one adder resolves it. The carry out of the
    // top position has no place to go and is dropped.
    assign w_star_ext = {1'b0, i_star};
    assign w_gen      = r_set & w_star_ext;
    assign w_sum      = w_star_ext + w_gen;
    assign w_carry    = w_sum ^ w_star_ext ^ w_gen;
    assign w_closed   = r_set | w_carry;

    // Literal and question mark positions step forward on a fitting byte.
    always_comb begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            w_hit[i] = w_closed[i] && i_valid[i] && !i_star[i] &&
                       (i_qmark[i] || (i_bytes[i] == i_char));
        end
    end

    // Star positions stay live and absorb the byte.
    assign w_next = (w_closed & w_star_ext) | {w_hit, 1'b0};

    always_comb begin
        n_set = r_set;
        if (i_op.start || i_op.txt_end) begin
            n_set = SW'(1);
        end else if (i_op.txt_step) begin
            n_set = w_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set <= SW'(1);
        end else begin
            r_set <= n_set;
        end
    end

    // The whole text matched when the end position is live after closure.
    assign o_matched = w_closed[i_len] && !i_ovf;

endmodule

// ===== design/glob_wildcard_matcher.sv =====
// ============================================================================
// Glob wildcard matcher
// Streams a glob pattern and then text bytes, and reports per text whether
// the whole text matched the pattern.
// ============================================================================
// Usage:
//   Input channel: tuser carries the command (start new pattern, pattern
//   character, text character, end of text) and tdata the character.
//   Issue a start, then the pattern characters, then any number of texts,
//   each as text characters closed by an end-of-text word. Letters are
//   folded to lower case on entry.
//   Output channel: one word per end-of-text, with the match bit and the
//   pattern overflow bit. A pattern longer than MAX_PATTERN sets overflow
//   and the match bit then reads 0.
//   Throughput: one word per cycle while no end-of-text word waits for the
//   output register; the active position set updates with one carry chain plus one byte compare per place.
//   The result of an end-of-text word passes through the input register
//   and then the output register.
//   Reset clears the pattern length, the overflow flag and the output.
//   When the receiver stalls, the pending result holds; other words keep
//   flowing, and an end-of-text word waits in the input register until the
//   output register is free.
// ============================================================================
module glob_wildcard_matcher
    import gwm_pkg::*;
#(
    parameter int MAX_PATTERN = GWM_MAX_PATTERN,
    localparam int LW = $clog2(MAX_PATTERN + 1)
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Input channel.
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,    // [7:0] char_code
    input  logic [1:0] i_s_axis_tuser,    // [1:0] func
    // Output channel.
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata     // [0] matched, [1] pattern_overflow, [7:2] zero
);

    logic       r_in_valid;
    logic [1:0] r_in_func;
    logic [7:0] r_in_char;
    logic       r_out_valid;
    logic       r_out_matched;
    logic       r_out_ovf;
    logic       w_go;
    logic       w_in_take;
    t_op        w_op;

    logic [LW-1:0]          w_len;
    logic                   w_ovf;
    logic [7:0]             w_bytes [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] w_star;
    logic [MAX_PATTERN-1:0] w_qmark;
    logic [MAX_PATTERN-1:0] w_valid;
    logic                   w_matched;

    // The registered word proceeds unless it is an end-of-text facing a full
    // output register that is not being drained.
    assign w_go = r_in_valid &&
                  ((r_in_func != FUNC_TXT_END) || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_go;
    assign w_in_take       = i_s_axis_tvalid && o_s_axis_tready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_func <= i_s_axis_tuser;
            r_in_char <= fold_lower(i_s_axis_tdata);
        end
    end

    // Command decode.
    always_comb begin
        w_op = '0;
        if (w_go) begin
            case (r_in_func)
                FUNC_START:    w_op.start    = 1'b1;
                FUNC_PAT_CHAR: w_op.pat_wr   = 1'b1;
                FUNC_TXT_CHAR: w_op.txt_step = 1'b1;
                FUNC_TXT_END:  w_op.txt_end  = 1'b1;
                default:       w_op          = '0;
            endcase
        end
    end

    gwm_pattern_store #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op),
        .i_char  (r_in_char),
        .o_len   (w_len),
        .o_ovf   (w_ovf),
        .o_bytes (w_bytes),
        .o_star  (w_star),
        .o_qmark (w_qmark),
        .o_valid (w_valid)
    );

    gwm_active_set #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_active (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op      (w_op),
        .i_char    (r_in_char),
        .i_len     (w_len),
        .i_ovf     (w_ovf),
        .i_bytes   (w_bytes),
        .i_star    (w_star),
        .i_qmark   (w_qmark),
        .i_valid   (w_valid),
        .o_matched (w_matched)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_op.txt_end) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_op.txt_end) begin
            r_out_matched <= w_matched;
            r_out_ovf     <= w_ovf;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_ovf, r_out_matched};

endmodule

// ===== design/gwm_checker.sv =====
// ============================================================================
// Glob wildcard matcher port checker
// Watches the ports of the matcher for result consistency and stall rules.
// ============================================================================
`include "glob_wildcard_matcher_defines.svh"

module gwm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata
);

    // A stalled result stays offered and unchanged.
    `GWM_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid, "result dropped while stalled")
    `GWM_ASSERT(a_out_stable, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata), "result changed while stalled")

    // An overflowed pattern never reports a match.
    `GWM_ASSERT(a_ovf_no_match, i_clk, i_rst_n, o_m_axis_tvalid |-> !(o_m_axis_tdata[0] && o_m_axis_tdata[1]), "match reported with pattern overflow")

    // Padding bits of a result word are zero.
    `GWM_ASSERT(a_pad_zero, i_clk, i_rst_n, o_m_axis_tvalid |-> (o_m_axis_tdata[7:2] == 6'd0), "nonzero padding in result word")

    // Right after reset no result is offered.
    `GWM_ASSERT_ALWAYS(a_rst_empty, i_clk, $rose(i_rst_n) |-> !o_m_axis_tvalid, "result offered after reset")

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
